// ===== design/scrolling_three_trace_plotter_core_defines.svh =====
// Assertion macros for the plotter RTL.
// Each macro expects the enclosing module to have clk; STTP_ASSERT also arst_n.
`ifndef SCROLLING_THREE_TRACE_PLOTTER_CORE_DEFINES_SVH
`define SCROLLING_THREE_TRACE_PLOTTER_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define STTP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define STTP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/sttp_pkg.sv =====
package sttp_pkg;

	localparam int ROW_W    = 10;
	localparam int COL_W    = 11;
	localparam int SAMPLE_W = 16;
	localparam int PIX_W    = 20;
	localparam int COLOR_W  = 8;
	localparam int QUOT_W   = 14;
	localparam int AXES     = 3;

	localparam int FIRST_COLUMN = 3;

	// Reciprocal of five scaled by 2^18; by 2^19 it serves for ten.
	localparam logic [15:0] RECIP_FIVE  = 16'd52429;
	localparam int          SHIFT_FIVE  = 18;
	localparam int          SHIFT_TEN   = 19;

	localparam logic [ROW_W-1:0] CENTER_ROW_RESET = 10'd300;
	localparam logic [ROW_W-1:0] MAX_ROW_RESET    = 10'd600;

	localparam logic [COLOR_W-1:0] COLOR_ON  = 8'hFF;
	localparam logic [COLOR_W-1:0] COLOR_OFF = 8'h00;

	// Register indexes, taken from paddr[2].
	localparam logic REG_CENTER_ROW = 1'b0;
	localparam logic REG_MAX_ROW    = 1'b1;

	typedef logic [AXES-1:0][SAMPLE_W-1:0] samples_t;
	typedef logic [AXES-1:0][ROW_W-1:0]    rows_t;

	typedef struct packed {
		rows_t            rows;
		rows_t            old;
		logic [COL_W-1:0] col;
		logic             first;
	} job_t;

endpackage

// ===== design/scrolling_three_trace_plotter_core.sv =====
// Scrolling three-trace strip chart plotter.
// Slave stream s_*: one accelerometer sample per request, tdata holds
// x_sample, y_sample and z_sample (16 bits signed each) from the lowest bit.
// Master stream m_*: one pixel write per request, tdata holds pixel_index,
// then colour bytes 0, 1 and 2; tlast marks the last write of a sample.
// Each sample yields an erase and a draw per axis (x, y, z in that order);
// during the first sweep of the column counter the erases are left out.
// APB port: center_row at address 0, max_row at address 4; pready is high.
// A sample passes the stage-one registers and the sequencer's job register;
// its writes leave through the output register. The sample rate is set by the
// single pixel write port, six writes per sample once erasing (three in the
// first sweep); a new sample is taken while the previous one is written out.
// The row history sits in a single-port-write, one-read synchronous RAM read
// when the sample enters and written back as the sample moves on from stage
// one to the write-out sequencer.
// Reset clears the column counter to its first column, sets the first-sweep
// flag and restores the register defaults; the RAM is not cleared, as its
// entries are only used for erases after a full sweep has written them.
// When the receiver stalls, the current write holds and, once the sample in
// flight and the one behind it are queued, s_tready drops.
module scrolling_three_trace_plotter_core #(
	parameter int FRAME_WIDTH  = 1024,
	parameter int SWEEP_LENGTH = 1022
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: x_sample [15:0], y_sample [31:16], z_sample [47:32]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	// m_tdata: pixel_index [19:0], color_byte0 [27:20], color_byte1 [35:28],
	// color_byte2 [43:36], zero padding [47:44]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sttp_pkg::*;

	localparam int SLOT_W   = $clog2(SWEEP_LENGTH);
	localparam int LAST_COL = FIRST_COLUMN + SWEEP_LENGTH - 1;

	// Configuration registers.
	logic [ROW_W-1:0] center_q, max_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_ROW_RESET;
			max_q    <= MAX_ROW_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_CENTER_ROW: center_q <= pwdata[ROW_W-1:0];
				REG_MAX_ROW:    max_q    <= pwdata[ROW_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CENTER_ROW: prdata = {22'd0, center_q};
			REG_MAX_ROW:    prdata = {22'd0, max_q};
			default:        prdata = '0;
		endcase
	end

	// Column counter and first-sweep flag advance with every accepted sample.
	logic [COL_W-1:0] col_q;
	logic             first_q;
	logic             accept;
	logic [31:0]      slot_full;
	logic [SLOT_W-1:0] slot;

	// A column outside the sweep falls back to the first history slot.
	assign slot_full = 32'(col_q) - 32'(FIRST_COLUMN);
	assign slot      = (slot_full >= 32'(SWEEP_LENGTH)) ? '0 : slot_full[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= COL_W'(FIRST_COLUMN);
			first_q <= 1'b1;
		end else if (accept) begin
			if (32'(col_q) >= 32'(LAST_COL)) begin
				col_q   <= COL_W'(FIRST_COLUMN);
				first_q <= 1'b0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage one: the quotients are registered, the history entry has been
	// read, and the rows are formed ready for the write-out sequencer.
	logic              s1_valid_q;
	logic [COL_W-1:0]  col_s1;
	logic              first_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              job_ready, advance;
	rows_t             rows;
	logic [$bits(rows_t)-1:0] hist_rdata;
	job_t              job;

	assign advance  = s1_valid_q && job_ready;
	assign s_tready = !s1_valid_q || job_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (advance)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col_q;
			first_s1 <= first_q;
			slot_s1  <= slot;
		end
	end

	sttp_row_map u_row_map (
		.clk        (clk),
		.load       (accept),
		.samples    (s_tdata),
		.center_row (center_q),
		.max_row    (max_q),
		.rows       (rows)
	);

	sttp_hist_ram #(
		.DEPTH (SWEEP_LENGTH),
		.AW    (SLOT_W),
		.DW    ($bits(rows_t))
	) u_hist_ram (
		.clk   (clk),
		.re    (accept),
		.raddr (slot),
		.rdata (hist_rdata),
		.we    (advance),
		.waddr (slot_s1),
		.wdata (rows)
	);

	assign job.rows  = rows;
	assign job.old   = hist_rdata;
	assign job.col   = col_s1;
	assign job.first = first_s1;

	sttp_emitter #(
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (s1_valid_q),
		.job       (job),
		.job_ready (job_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== design/sttp_row_map.sv =====
module sttp_row_map (
	input  logic              clk,
	input  logic              load,
	input  sttp_pkg::samples_t samples,
	input  logic [9:0]        center_row,
	input  logic [9:0]        max_row,
	output sttp_pkg::rows_t   rows
);
	import sttp_pkg::*;

	logic [AXES-1:0][QUOT_W-1:0] quot_s1;
	logic [AXES-1:0]             neg_s1;

	// Magnitude times the reciprocal, registered; the shift is only wiring.
	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			logic [SAMPLE_W:0]    ext;
			logic [SAMPLE_W:0]    mag;
			logic [SAMPLE_W+16:0] prod;
			ext  = {samples[a][SAMPLE_W-1], samples[a]};
			mag  = samples[a][SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - ext) : ext;
			prod = (SAMPLE_W+17)'(mag) * (SAMPLE_W+17)'(RECIP_FIVE);
			if (load) begin
				neg_s1[a]  <= samples[a][SAMPLE_W-1];
				quot_s1[a] <= (a == AXES - 1) ? QUOT_W'(prod >> SHIFT_TEN)
				                              : QUOT_W'(prod >> SHIFT_FIVE);
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			logic signed [15:0] r;
			r = neg_s1[a] ? ($signed({6'd0, center_row}) + $signed({2'd0, quot_s1[a]}))
			              : ($signed({6'd0, center_row}) - $signed({2'd0, quot_s1[a]}));
			if (r[15])
				rows[a] = '0;
			else if (r > $signed({6'd0, max_row}))
				rows[a] = max_row;
			else
				rows[a] = r[ROW_W-1:0];
		end
	end

endmodule

// ===== design/sttp_hist_ram.sv =====
module sttp_hist_ram #(
	parameter int DEPTH = 1022,
	parameter int AW    = 10,
	parameter int DW    = 30
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// A read of the entry being written in the same cycle returns the new data.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr))
				rdata_q <= wdata;
			else
				rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sttp_emitter.sv =====
`include "scrolling_three_trace_plotter_core_defines.svh"

module sttp_emitter #(
	parameter int FRAME_WIDTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  sttp_pkg::job_t job,
	output logic           job_ready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [47:0]    m_tdata,
	output logic           m_tlast
);
	import sttp_pkg::*;

	localparam logic [2:0] STEP_ERASE_X = 3'd0;
	localparam logic [2:0] STEP_DRAW_X  = 3'd1;
	localparam logic [2:0] STEP_LAST    = 3'd5;
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	job_t               job_q;
	logic               busy_q;
	logic [2:0]         step_q;
	logic               out_valid_q;
	logic [PIX_W-1:0]   pix_q;
	logic [COLOR_W-1:0] b0_q, b1_q, b2_q;
	logic               last_q;

	logic               out_free, issue, last_step, load, draw;
	logic [1:0]         axis;
	logic [ROW_W-1:0]   row_sel;
	logic [PIX_W-1:0]   pix_next;

	assign out_free  = !out_valid_q || m_tready;
	assign issue     = busy_q && out_free;
	assign last_step = (step_q == STEP_LAST);
	assign job_ready = !busy_q || (issue && last_step);
	assign load      = job_valid && job_ready;
	assign axis      = step_q[2:1];
	assign draw      = step_q[0];

	always_comb begin
		case (axis)
			AXIS_X:  row_sel = draw ? job_q.rows[0] : job_q.old[0];
			AXIS_Y:  row_sel = draw ? job_q.rows[1] : job_q.old[1];
			AXIS_Z:  row_sel = draw ? job_q.rows[2] : job_q.old[2];
			default: row_sel = '0;
		endcase
		pix_next = PIX_W'(row_sel) * PIX_W'(FRAME_WIDTH) + PIX_W'(FRAME_WIDTH)
		         - PIX_W'(job_q.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_ERASE_X;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= job.first ? STEP_DRAW_X : STEP_ERASE_X;
			end else if (issue && last_step) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				step_q <= step_q + (job_q.first ? 3'd2 : 3'd1);
			end
			if (issue)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			job_q <= job;
		if (issue) begin
			pix_q  <= pix_next;
			b0_q   <= (draw && axis == AXIS_X) ? COLOR_ON : COLOR_OFF;
			b1_q   <= (draw && axis == AXIS_Z) ? COLOR_ON : COLOR_OFF;
			b2_q   <= (draw && axis == AXIS_Y) ? COLOR_ON : COLOR_OFF;
			last_q <= last_step;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, b2_q, b1_q, b0_q, pix_q};
	assign m_tlast  = last_q;

	`STTP_ASSERT(a_no_job_while_blocked, busy_q && out_valid_q && !m_tready |-> !job_ready, "job taken while output stalled")
	`STTP_ASSERT(a_last_is_draw, out_valid_q && last_q |-> (b0_q | b1_q | b2_q) != COLOR_OFF, "last write is not a draw")
	`STTP_ASSERT(a_first_sweep_no_erase, busy_q && job_q.first |-> draw, "erase issued during first sweep")

endmodule

// ===== tb/tb_scrolling_three_trace_plotter_core.sv =====
module tb_scrolling_three_trace_plotter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sttp_pkg::*;

	localparam int FRAME_WIDTH   = 1024;
	localparam int SWEEP_LENGTH  = 1022;
	localparam int CLK_PERIOD    = 10;
	localparam int XY_DIVISOR    = 5;
	localparam int Z_DIVISOR     = 10;
	localparam int AXIS_X        = 0;
	localparam int AXIS_Y        = 1;
	localparam int AXIS_Z        = 2;
	// Twelve phases of 26 random samples; every phase but the first writes its
	// own register settings, and the pacing on either side cycles through four sets.
	localparam int PHASES        = 12;
	localparam int PHASE_SAMPLES = 26;
	localparam int LONG_HOLD     = 300;
	localparam int TAIL_CYCLES   = 20;
	localparam int MAX_REPORTS   = 50;

	// One expected pixel write, in the order the fields leave the block.
	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COLOR_W-1:0] byte0;
		logic [COLOR_W-1:0] byte1;
		logic [COLOR_W-1:0] byte2;
		logic               last;
	} pixel_write_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Samples waiting to be offered, and pixel writes still owed by the block.
	logic [47:0]  pending_samples[$];
	pixel_write_t pixel_writes_due[$];

	// Our own copy of the plotter state and its two registers.
	logic [COL_W-1:0] sweep_col   = COL_W'(FIRST_COLUMN);
	logic             first_sweep = 1'b1;
	rows_t            row_history[SWEEP_LENGTH];
	logic [ROW_W-1:0] center_cfg  = CENTER_ROW_RESET;
	logic [ROW_W-1:0] max_cfg     = MAX_ROW_RESET;

	// Working variables of the prediction in the driver.
	int    hist_slot;
	int    axis;
	rows_t fresh_rows;
	rows_t prior_rows;

	// Pacing, set per phase by the sequencer.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	// Long hold-offs are ordered by the sequencer and carried out by the receiver.
	int hold_orders = 0;
	int hold_taken  = 0;
	int hold_left   = 0;

	int           mismatches = 0;
	pixel_write_t due_write;

	scrolling_three_trace_plotter_core #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.SWEEP_LENGTH(SWEEP_LENGTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Row for one axis: the centre row minus the sample over the divisor, where
	// the division truncates towards zero, then clamped to 0..max_row.
	function automatic logic [ROW_W-1:0] plot_row(input logic signed [SAMPLE_W-1:0] sample,
			input int divisor);
		int r;
		r = int'(center_cfg) - int'(sample) / divisor;
		if (r < 0)
			return '0;
		if (r > int'(max_cfg))
			return max_cfg;
		return ROW_W'(r);
	endfunction

	// Pixel number of a row at a column, counted from the right edge of the frame.
	function automatic logic [PIX_W-1:0] pixel_at(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [31:0] p;
		p = 32'(row) * 32'(FRAME_WIDTH) + 32'(FRAME_WIDTH) - 32'(col);
		return p[PIX_W-1:0];
	endfunction

	function automatic logic [47:0] sample_word(input int x, input int y, input int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	// Half full-range values, which clamp often, with a share close to zero to
	// exercise the truncation and a share that lands inside the plotting band.
	function automatic logic [SAMPLE_W-1:0] random_axis();
		case ($urandom_range(3))
			0: begin
				return SAMPLE_W'(int'($urandom_range(40)) - 20);
			end
			1: begin
				return SAMPLE_W'(int'($urandom_range(12000)) - 6000);
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		// Only the first MAX_REPORTS are printed so that a broken block cannot flood the log.
		if (mismatches < MAX_REPORTS)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Returns on a falling edge once every sample is in and every write is out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || pixel_writes_due.size() != 0);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value at
	// the edge that closes the access cycle. The unused upper bits carry noise.
	task automatic write_register(input logic reg_sel, input logic [ROW_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {22'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_CENTER_ROW)
			center_cfg = value;
		else
			max_cfg = value;
	endtask

	// Driver. A request that was taken at this edge is run through the
	// prediction; the next sample is then offered, subject to the idle rate. A
	// request still waiting for s_tready is held unchanged.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				hist_slot = int'(sweep_col) - FIRST_COLUMN;
				if (hist_slot < 0 || hist_slot >= SWEEP_LENGTH)
					hist_slot = 0;
				prior_rows = row_history[hist_slot];
				fresh_rows[AXIS_X] = plot_row(s_tdata[15:0], XY_DIVISOR);
				fresh_rows[AXIS_Y] = plot_row(s_tdata[31:16], XY_DIVISOR);
				fresh_rows[AXIS_Z] = plot_row(s_tdata[47:32], Z_DIVISOR);
				// Erase then draw for each axis in turn; the erases start with
				// the second sweep, once every column holds a stored row.
				for (axis = 0; axis < AXES; axis++) begin
					if (!first_sweep)
						pixel_writes_due.push_back(pixel_write_t'{
							pixel_at(prior_rows[axis], sweep_col),
							COLOR_OFF, COLOR_OFF, COLOR_OFF, 1'b0});
					pixel_writes_due.push_back(pixel_write_t'{
						pixel_at(fresh_rows[axis], sweep_col),
						(axis == AXIS_X) ? COLOR_ON : COLOR_OFF,
						(axis == AXIS_Z) ? COLOR_ON : COLOR_OFF,
						(axis == AXIS_Y) ? COLOR_ON : COLOR_OFF,
						1'(axis == AXES - 1)});
				end
				row_history[hist_slot] = fresh_rows;
				if (int'(sweep_col) >= FIRST_COLUMN + SWEEP_LENGTH - 1) begin
					sweep_col   = COL_W'(FIRST_COLUMN);
					first_sweep = 1'b0;
				end else begin
					sweep_col = sweep_col + COL_W'(1);
				end
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_samples.pop_front();
				end else begin
					s_tvalid <= 1'b0;
					s_tdata  <= 48'({$urandom, $urandom});
				end
			end
		end
	end

	// Monitor and receiver. A pixel write taken at this edge is checked field by
	// field against the oldest one owed; then m_tready for the next cycle is
	// chosen, with any ordered long hold-off taking precedence over random stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pixel_writes_due.size() == 0) begin
					report_mismatch("unexpected pixel write", m_tdata, 0);
				end else begin
					due_write = pixel_writes_due.pop_front();
					if (m_tdata[19:0] !== due_write.pixel)
						report_mismatch("pixel_index", m_tdata[19:0], due_write.pixel);
					if (m_tdata[27:20] !== due_write.byte0)
						report_mismatch("color_byte0", m_tdata[27:20], due_write.byte0);
					if (m_tdata[35:28] !== due_write.byte1)
						report_mismatch("color_byte1", m_tdata[35:28], due_write.byte1);
					if (m_tdata[43:36] !== due_write.byte2)
						report_mismatch("color_byte2", m_tdata[43:36], due_write.byte2);
					if (m_tdata[47:44] !== 4'h0)
						report_mismatch("tdata padding", m_tdata[47:44], 0);
					if (m_tlast !== due_write.last)
						report_mismatch("last_write", m_tlast, due_write.last);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_taken != hold_orders) begin
				hold_taken++;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Sequencer: reset, a directed set at the reset settings, then phases of
	// random samples. Between phases the sender waits for every write to come
	// out, so the registers are only rewritten while the block is idle.
	initial begin
		int               p;
		logic [ROW_W-1:0] centre;
		logic [ROW_W-1:0] top_row;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero, the extremes of every field, truncation either side of zero,
		// rows landing exactly on, just inside and just beyond the clamps, and
		// alternating bit patterns.
		pending_samples.push_back(sample_word(0, 0, 0));
		pending_samples.push_back(sample_word(32767, -32768, 32767));
		pending_samples.push_back(sample_word(-32768, 32767, -32768));
		pending_samples.push_back(sample_word(-32767, -1, 1));
		pending_samples.push_back(sample_word(-1, 1, -9));
		pending_samples.push_back(sample_word(-4, 4, 9));
		pending_samples.push_back(sample_word(-5, 5, -10));
		pending_samples.push_back(sample_word(1500, -1500, 3000));
		pending_samples.push_back(sample_word(1505, -1505, 3010));
		pending_samples.push_back(sample_word(1495, -1495, 2990));
		pending_samples.push_back(sample_word(-1500, 1500, -3000));
		pending_samples.push_back(sample_word('h5555, 'hAAAA, 'h5555));
		pending_samples.push_back(sample_word('hAAAA, 'h5555, 'hAAAA));

		for (p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				repeat (TAIL_CYCLES) @(posedge clk);
				case (p)
					1: begin
						centre  = '0;
						top_row = '0;
					end
					2: begin
						centre  = '1;
						top_row = '1;
					end
					3: begin
						centre  = '1;
						top_row = '0;
					end
					4: begin
						centre  = '0;
						top_row = '1;
					end
					5: begin
						centre  = 10'd512;
						top_row = '1;
					end
					6: begin
						centre  = 10'd700;
						top_row = 10'd400;
					end
					7: begin
						centre  = CENTER_ROW_RESET;
						top_row = MAX_ROW_RESET;
					end
					default: begin
						centre  = ROW_W'($urandom);
						top_row = ROW_W'($urandom);
					end
				endcase
				write_register(REG_CENTER_ROW, centre);
				write_register(REG_MAX_ROW, top_row);
				@(negedge clk);
			end
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 49;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 49;
				end
				default: begin
					send_idle_pct = 14;
					stall_pct     = 14;
				end
			endcase
			repeat (PHASE_SAMPLES)
				pending_samples.push_back({random_axis(), random_axis(), random_axis()});
			// With a full queue of samples on offer, a long hold-off on the
			// write side backs the block up until it refuses new requests.
			if (p % 4 == 2)
				hold_orders++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** scrolling_three_trace_plotter_core: PASSED **");
		else
			$display("** scrolling_three_trace_plotter_core: FAILED **");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#4ms;
		$display("** scrolling_three_trace_plotter_core: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/sttp_pkg.sv
design/sttp_row_map.sv
design/sttp_hist_ram.sv
design/sttp_emitter.sv
design/scrolling_three_trace_plotter_core.sv
tb/tb_scrolling_three_trace_plotter_core.sv
